// ===== src/wpe_pkg.sv =====
// Shared widths, limits, config bundle and helper functions for the
// waveform peak envelope block. No dependencies.

package wpe_pkg;

  localparam int unsigned MAX_COLUMNS  = 4096;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned FIFO_DEPTH   = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned COLCFG_W = 13;
  localparam int unsigned CHCFG_W  = 4;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned CFGIDX_W = 2;
  localparam int unsigned CFGDAT_W = 32;

  // Columns are capped at 64 per frame.
  localparam int unsigned COL_PER_FRAME_SHIFT = 6;
  localparam int unsigned LIM_W = FRAME_W + COL_PER_FRAME_SHIFT;

  localparam int unsigned CH_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_CHANNELS);
  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int unsigned LEVEL_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned NUM_W  = $clog2(RESULT_LIMIT + 1);

  // Mean by reciprocal: q = (|sum| * ceil(2^K / ch)) >> K, exact for |sum| <= 2^(SUM_W-1).
  localparam int unsigned RECIP_SHIFT = SUM_W + 2;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_CHANNELS+1] = '{
    RECIP_W'(0),
    RECIP_W'(2097152),
    RECIP_W'(1048576),
    RECIP_W'(699051),
    RECIP_W'(524288),
    RECIP_W'(419431),
    RECIP_W'(349526),
    RECIP_W'(299594),
    RECIP_W'(262144)
  };

  typedef enum logic [CFGIDX_W-1:0] {
    CFG_FRAME_COUNT   = 2'd0,
    CFG_COLUMN_COUNT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  // Effective settings, derived from the config registers.
  typedef struct packed {
    logic                active;
    logic [FRAME_W-1:0]  frames;
    logic [COLCFG_W-1:0] columns;
    logic [CH_W-1:0]     channels;
  } cfg_t;

  typedef struct packed {
    logic                done;
    logic [FRAME_W-1:0]  quot;
    logic [COLCFG_W-1:0] rmd;
  } div_res_t;

  function automatic logic [CH_W-1:0] eff_channels(input logic [CHCFG_W-1:0] cc);
    logic [CH_W-1:0] r;
    if (cc == '0) begin
      r = CH_W'(1);
    end else if (cc > CHCFG_W'(MAX_CHANNELS)) begin
      r = CH_W'(MAX_CHANNELS);
    end else begin
      r = CH_W'(cc);
    end
    return r;
  endfunction

  function automatic logic [COLCFG_W-1:0] eff_columns(input logic [FRAME_W-1:0]  n,
                                                      input logic [COLCFG_W-1:0] cc);
    logic [COLCFG_W-1:0] c;
    logic [LIM_W-1:0]    lim;
    c   = (cc > COLCFG_W'(MAX_COLUMNS)) ? COLCFG_W'(MAX_COLUMNS) : cc;
    lim = {n, {COL_PER_FRAME_SHIFT{1'b0}}};
    if (LIM_W'(c) > lim) begin
      c = COLCFG_W'(lim);
    end
    return c;
  endfunction

endpackage

// ===== src/waveform_peak_envelope.sv =====
// Top level of the waveform peak envelope block: config registers, front,
// queue, divider and back. Depends on wpe_pkg and the wpe_* modules.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / sample_i): one Q1.15 channel
//   sample per word, channels interleaved frame by frame. A word moves at a
//   rising edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i): one word per finished
//   column with its index, min and max mono value and a last-column flag.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0 frame count,
//   1 column count, 2 channel count. Ready is always high. Any write,
//   to any index, restarts the clip. Write only while the block is idle.
// Flow:
//   The front takes one sample per cycle while in_stall_o is low; a finished
//   frame passes registers p1 and p2 into the queue. Per frame the back
//   visits S_IDLE and S_CHECK, per result word S_CHECK and S_CLAMP_LOOP; it
//   pops a closing frame in S_IDLE and registers its result in S_CHECK.
//   The slower of the input and the back loop sets the sustained frame rate.
// Reset and config: after reset or a config write the back runs a serial
//   divide of frame count by columns, then S_CLAMP_IDLE, before it drains
//   the queue; samples keep flowing until the 8-deep queue fills.
// Stall: a stalled result word holds; the back waits, the queue fills,
//   then in_stall_o rises.

module waveform_peak_envelope (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wpe_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wpe_pkg::COL_W-1:0]           column_o,
  output logic signed [wpe_pkg::SAMPLE_W-1:0] low_peak_o,
  output logic signed [wpe_pkg::SAMPLE_W-1:0] high_peak_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wpe_pkg::CFGIDX_W-1:0]        cfg_index_i,
  input  logic [wpe_pkg::CFGDAT_W-1:0]        cfg_data_i
);
  import wpe_pkg::*;

  logic [FRAME_W-1:0]  frame_count_q;
  logic [COLCFG_W-1:0] column_count_q;
  logic [CHCFG_W-1:0]  channel_count_q;
  logic                cfg_we;
  cfg_t                cfg;

  logic                  push, pop, fifo_valid, div_start;
  logic signed [SAMPLE_W-1:0] mono, fifo_data;
  logic [LEVEL_W-1:0]    level;
  div_res_t              div_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Effective settings: clamp columns and channels, gate on a non-empty clip.
  always_comb begin
    cfg.frames   = frame_count_q;
    cfg.columns  = eff_columns(frame_count_q, column_count_q);
    cfg.channels = eff_channels(channel_count_q);
    cfg.active   = (frame_count_q != '0) && (cfg.columns != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q   <= FRAME_W'(1);
      column_count_q  <= COLCFG_W'(1024);
      channel_count_q <= CHCFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_FRAME_COUNT:   frame_count_q   <= cfg_data_i[FRAME_W-1:0];
        CFG_COLUMN_COUNT:  column_count_q  <= cfg_data_i[COLCFG_W-1:0];
        CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CHCFG_W-1:0];
        default: begin
          // Unmapped index: no register changes, the clip still restarts.
        end
      endcase
    end
  end

  wpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_we),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .level_i    (level),
    .push_o     (push),
    .mono_o     (mono)
  );

  wpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (cfg_we),
    .push_i  (push),
    .data_i  (mono),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .level_o (level)
  );

  wpe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg.frames),
    .divisor_i  (cfg.columns),
    .res_o      (div_res)
  );

  wpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we),
    .cfg_i        (cfg),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .pop_o        (pop),
    .div_start_o  (div_start),
    .div_i        (div_res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .column_o     (column_o),
    .low_peak_o   (low_peak_o),
    .high_peak_o  (high_peak_o),
    .last_o       (last_o)
  );

endmodule

// ===== src/wpe_fifo.sv =====
// Short word queue between the front and back parts of the envelope block.
// Depends on wpe_pkg.

module wpe_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               flush_i,
  input  logic                               push_i,
  input  logic signed [wpe_pkg::SAMPLE_W-1:0] data_i,
  input  logic                               pop_i,
  output logic                               valid_o,
  output logic signed [wpe_pkg::SAMPLE_W-1:0] data_o,
  output logic [wpe_pkg::LEVEL_W-1:0]        level_o
);
  import wpe_pkg::*;

  logic signed [SAMPLE_W-1:0] mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [LEVEL_W-1:0] level_q;
  logic               do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else if (flush_i) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   level_q <= level_q + LEVEL_W'(1);
        2'b01:   level_q <= level_q - LEVEL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

// ===== src/wpe_front.sv =====
// Front part: takes interleaved samples, sums a frame and forms the mono
// mean in a two-stage reciprocal multiply. Depends on wpe_pkg.

module wpe_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  wpe_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wpe_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [wpe_pkg::LEVEL_W-1:0]         level_i,
  output logic                                push_o,
  output logic signed [wpe_pkg::SAMPLE_W-1:0] mono_o
);
  import wpe_pkg::*;

  logic signed [SUM_W-1:0] sum_q, sum_next, sample_ext;
  logic [IDX_W-1:0]        idx_q;
  logic                    accept, frame_done;
  logic [LEVEL_W+1:0]      occupancy;

  logic                    p1_v_q, p1_neg_q;
  logic [SUM_W-1:0]        p1_mag_q;
  logic [RECIP_W-1:0]      p1_recip_q;
  logic                    p2_v_q, p2_neg_q;
  logic [PROD_W-1:0]       p2_prod_q;
  logic [SAMPLE_W:0]       quo;

  // Hold off while the queue could not take every frame in flight.
  assign occupancy  = (LEVEL_W+2)'(level_i) + (LEVEL_W+2)'(p1_v_q) + (LEVEL_W+2)'(p2_v_q);
  assign in_stall_o = (occupancy >= (LEVEL_W+2)'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign sample_ext = SUM_W'(sample_i);
  assign sum_next   = sum_q + sample_ext;
  assign frame_done = accept && cfg_i.active &&
                      ((CH_W'(idx_q) + CH_W'(1)) == cfg_i.channels);

  assign quo    = p2_prod_q[RECIP_SHIFT +: SAMPLE_W+1];
  assign push_o = p2_v_q;
  assign mono_o = SAMPLE_W'(p2_neg_q ? (~quo + (SAMPLE_W+1)'(1)) : quo);

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      p1_neg_q   <= sum_next[SUM_W-1];
      p1_mag_q   <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
      p1_recip_q <= RECIP_TABLE[cfg_i.channels];
    end
    if (p1_v_q) begin
      p2_neg_q  <= p1_neg_q;
      p2_prod_q <= PROD_W'(p1_mag_q) * PROD_W'(p1_recip_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      idx_q  <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else if (restart_i) begin
      sum_q  <= '0;
      idx_q  <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      if (accept && cfg_i.active) begin
        if (frame_done) begin
          sum_q <= '0;
          idx_q <= '0;
        end else begin
          sum_q <= sum_next;
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      p1_v_q <= frame_done;
      p2_v_q <= p1_v_q;
    end
  end

endmodule

// ===== src/wpe_divider.sv =====
// Restoring divider, one quotient bit per cycle: frame count by column
// count, used to step column boundaries. Depends on wpe_pkg.

module wpe_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wpe_pkg::FRAME_W-1:0]    dividend_i,
  input  logic [wpe_pkg::COLCFG_W-1:0]   divisor_i,
  output wpe_pkg::div_res_t              res_o
);
  import wpe_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_W);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [FRAME_W-1:0]    quot_q;
  logic [COLCFG_W-1:0]   rmd_q, dvs_q;
  logic [COLCFG_W:0]     shifted;
  logic                  ge;

  assign shifted = {rmd_q, quot_q[FRAME_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rmd  = rmd_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rmd_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[FRAME_W-2:0], ge};
      rmd_q  <= COLCFG_W'(ge ? (shifted - {1'b0, dvs_q}) : shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(FRAME_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/wpe_back.sv =====
// Back part: tracks column boundaries and running min/max per frame and
// emits one result word per finished column. Depends on wpe_pkg.

module wpe_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  wpe_pkg::cfg_t                       cfg_i,
  input  logic                                fifo_valid_i,
  input  logic signed [wpe_pkg::SAMPLE_W-1:0] fifo_data_i,
  output logic                                pop_o,
  output logic                                div_start_o,
  input  wpe_pkg::div_res_t                   div_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wpe_pkg::COL_W-1:0]           column_o,
  output logic signed [wpe_pkg::SAMPLE_W-1:0] low_peak_o,
  output logic signed [wpe_pkg::SAMPLE_W-1:0] high_peak_o,
  output logic                                last_o
);
  import wpe_pkg::*;

  typedef enum logic [2:0] {
    S_DIV_START,
    S_DIV_WAIT,
    S_CLAMP_IDLE,
    S_CLAMP_LOOP,
    S_IDLE,
    S_CHECK
  } state_e;

  state_e                   state_q;
  logic [FRAME_W-1:0]       quot_q, raw_start_q, raw_end_q, end_q, frame_q;
  logic [COLCFG_W-1:0]      rmd_q, rem_q;
  logic [COL_W-1:0]         col_q;
  logic [NUM_W-1:0]         n_q;
  logic signed [SAMPLE_W-1:0] m_q, low_q, high_q;

  logic                     out_valid_q, last_q;
  logic [COL_W-1:0]         column_q;
  logic signed [SAMPLE_W-1:0] out_low_q, out_high_q;

  logic [FRAME_W:0]         lo_bound, end_bound, frame_next;
  logic [FRAME_W-1:0]       clamped, end_adv;
  logic [COLCFG_W:0]        rsum;
  logic [COLCFG_W-1:0]      rem_adv;
  logic                     carry, hit, is_last, out_free, start_hit;
  logic signed [SAMPLE_W-1:0] new_low, new_high;

  always_comb begin
    lo_bound  = {1'b0, raw_start_q} + (FRAME_W+1)'(1);
    end_bound = ({1'b0, raw_end_q} < lo_bound) ? lo_bound : {1'b0, raw_end_q};
    clamped   = (end_bound > {1'b0, cfg_i.frames}) ? cfg_i.frames : end_bound[FRAME_W-1:0];

    frame_next = {1'b0, frame_q} + (FRAME_W+1)'(1);
    hit        = (frame_next >= {1'b0, end_q}) && (n_q < NUM_W'(RESULT_LIMIT));
    is_last    = ((COLCFG_W'(col_q) + COLCFG_W'(1)) >= cfg_i.columns);

    rsum    = {1'b0, rem_q} + {1'b0, rmd_q};
    carry   = (rsum >= {1'b0, cfg_i.columns});
    rem_adv = COLCFG_W'(carry ? (rsum - {1'b0, cfg_i.columns}) : rsum);
    end_adv = raw_end_q + quot_q + FRAME_W'(carry);

    start_hit = (frame_q == raw_start_q);
    new_low   = (start_hit || fifo_data_i < low_q)  ? fifo_data_i : low_q;
    new_high  = (start_hit || fifo_data_i > high_q) ? fifo_data_i : high_q;
    out_free  = !out_valid_q || !out_stall_i;
  end

  assign pop_o       = (state_q == S_IDLE) && fifo_valid_i;
  assign div_start_o = (state_q == S_DIV_START);
  assign out_valid_o = out_valid_q;
  assign column_o    = column_q;
  assign low_peak_o  = out_low_q;
  assign high_peak_o = out_high_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_DIV_START;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      column_q    <= '0;
      out_low_q   <= '0;
      out_high_q  <= '0;
      quot_q      <= '0;
      rmd_q       <= '0;
      raw_start_q <= '0;
      raw_end_q   <= '0;
      end_q       <= '0;
      rem_q       <= '0;
      frame_q     <= '0;
      col_q       <= '0;
      n_q         <= '0;
      m_q         <= '0;
      low_q       <= '0;
      high_q      <= '0;
    end else if (restart_i) begin
      state_q     <= S_DIV_START;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_DIV_START: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_i.done) begin
            quot_q      <= div_i.quot;
            rmd_q       <= div_i.rmd;
            raw_start_q <= '0;
            raw_end_q   <= div_i.quot;
            rem_q       <= div_i.rmd;
            col_q       <= '0;
            frame_q     <= '0;
            low_q       <= '0;
            high_q      <= '0;
            state_q     <= S_CLAMP_IDLE;
          end
        end
        S_CLAMP_IDLE: begin
          end_q   <= clamped;
          state_q <= S_IDLE;
        end
        S_CLAMP_LOOP: begin
          end_q   <= clamped;
          state_q <= S_CHECK;
        end
        S_IDLE: begin
          if (fifo_valid_i) begin
            m_q     <= fifo_data_i;
            low_q   <= new_low;
            high_q  <= new_high;
            n_q     <= '0;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (hit) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              column_q    <= col_q;
              out_low_q   <= low_q;
              out_high_q  <= high_q;
              last_q      <= is_last;
              n_q         <= n_q + NUM_W'(1);
              if (is_last) begin
                // End of clip: start over on the next frame.
                raw_start_q <= '0;
                raw_end_q   <= quot_q;
                rem_q       <= rmd_q;
                col_q       <= '0;
                frame_q     <= '0;
                low_q       <= '0;
                high_q      <= '0;
                state_q     <= S_CLAMP_IDLE;
              end else begin
                col_q       <= col_q + COL_W'(1);
                raw_start_q <= raw_end_q;
                raw_end_q   <= end_adv;
                rem_q       <= rem_adv;
                if (raw_end_q == frame_q) begin
                  low_q  <= m_q;
                  high_q <= m_q;
                end
                state_q <= S_CLAMP_LOOP;
              end
            end
          end else begin
            frame_q <= frame_next[FRAME_W-1:0];
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_DIV_START;
        end
      endcase
    end
  end

endmodule

// ===== src/wpe_checker.sv =====
// Port-level checks for waveform_peak_envelope and the bind that attaches
// them. Depends on wpe_pkg.

module wpe_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [wpe_pkg::COL_W-1:0]           column_o,
  input logic signed [wpe_pkg::SAMPLE_W-1:0] low_peak_o,
  input logic signed [wpe_pkg::SAMPLE_W-1:0] high_peak_o,
  input logic                                last_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o
);
  import wpe_pkg::*;

  logic             out_acc, cfg_acc, in_acc;
  logic [COL_W-1:0] exp_col_q;

  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign in_acc  = in_valid_i && !in_stall_o;

  // Track the column the next word must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_col_q <= '0;
    end else if (cfg_acc) begin
      exp_col_q <= '0;
    end else if (out_acc) begin
      exp_col_q <= last_o ? '0 : (exp_col_q + COL_W'(1));
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !cfg_acc |=>
      out_valid_o && $stable(column_o) && $stable(low_peak_o) &&
      $stable(high_peak_o) && $stable(last_o))
    else $error("stalled result word changed");

  a_column_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> column_o == exp_col_q)
    else $error("column index out of sequence");

  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> low_peak_o <= high_peak_o)
    else $error("low peak above high peak");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc && !in_acc |=> !out_valid_o)
    else $error("result word survived a config write");

endmodule

bind waveform_peak_envelope wpe_checker u_wpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .column_o    (column_o),
  .low_peak_o  (low_peak_o),
  .high_peak_o (high_peak_o),
  .last_o      (last_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
